/* hdl/lrpp_pkg.sv */
// ----------------------------------------------------------------------------
// Reflector pair pose package
// Shared widths, constants, codes, types and the arctangent table.
// ----------------------------------------------------------------------------
package lrpp_pkg;

    localparam int MAX_SCAN_SAMPLES  = 2048;
    localparam int CORDIC_ITERATIONS = 16;

    localparam int IDX_W  = $clog2(MAX_SCAN_SAMPLES);
    localparam int RUN_W  = IDX_W + 1;
    localparam int ANG_W  = IDX_W + 20;
    localparam int Q_W    = ANG_W + 14;
    localparam int CMP_W  = Q_W + 1;
    localparam int RED_K  = Q_W - 32;
    localparam int SUM_W  = IDX_W + 18;
    localparam int DIV_W  = SUM_W + 1;
    localparam int CW     = 34;
    localparam int ZW     = 36;
    localparam int PW     = CW + 17;
    localparam int CNT_W  = 5;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [1:0] CFG_THRESHOLD   = 2'd0;
    localparam logic [1:0] CFG_ANGLE_START = 2'd1;
    localparam logic [1:0] CFG_ANGLE_STEP  = 2'd2;

    localparam logic [1:0] STAT_POSE_VALID = 2'd0;
    localparam logic [1:0] STAT_TOO_FEW    = 2'd1;
    localparam logic [1:0] STAT_TOO_MANY   = 2'd2;

    localparam logic KIND_CENTROID = 1'b0;
    localparam logic KIND_SUMMARY  = 1'b1;

    localparam logic [15:0] THRESHOLD_RESET = 16'd4048;

    localparam logic [33:0]          TWO_PI_U = 34'd6746518852;
    localparam logic signed [ZW-1:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [ZW-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [CW-1:0] GAIN_Q30    = 34'sd652032874;

    typedef struct packed {
        logic [15:0]             range_mm;
        logic                    hit;
        logic                    eos;
        logic signed [ANG_W-1:0] angle;
    } lrpp_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REDUCE,
        S_FOLD,
        S_QUAD,
        S_ROT,
        S_MUL,
        S_ACC,
        S_DINIT,
        S_DIV,
        S_CENT,
        S_SUMPREP,
        S_DOT,
        S_ORIENT,
        S_VEC,
        S_VFIN,
        S_EMIT
    } lrpp_state_t;

    function automatic logic signed [ZW-1:0] atan_q30(input logic [CNT_W-1:0] i);
        logic signed [ZW-1:0] a;
        case (i)
            5'd0:  a = 36'sd843314857;
            5'd1:  a = 36'sd497837829;
            5'd2:  a = 36'sd263043837;
            5'd3:  a = 36'sd133525159;
            5'd4:  a = 36'sd67021687;
            5'd5:  a = 36'sd33543516;
            5'd6:  a = 36'sd16775851;
            5'd7:  a = 36'sd8388437;
            5'd8:  a = 36'sd4194283;
            5'd9:  a = 36'sd2097149;
            5'd10: a = 36'sd1048576;
            5'd11: a = 36'sd524288;
            5'd12: a = 36'sd262144;
            5'd13: a = 36'sd131072;
            5'd14: a = 36'sd65536;
            5'd15: a = 36'sd32768;
            5'd16: a = 36'sd16384;
            5'd17: a = 36'sd8192;
            5'd18: a = 36'sd4096;
            5'd19: a = 36'sd2048;
            5'd20: a = 36'sd1024;
            5'd21: a = 36'sd512;
            5'd22: a = 36'sd256;
            5'd23: a = 36'sd128;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

/* hdl/lrpp_front.sv */
// ----------------------------------------------------------------------------
// Reflector pair pose front end
// Holds the configuration, counts samples, forms the sample angle and
// classifies each sample against the intensity threshold.
// ----------------------------------------------------------------------------
module lrpp_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [1:0]               cfg_index,
    input  logic [18:0]              cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [15:0]              range_mm,
    input  logic [15:0]              intensity,
    input  logic                     end_of_scan,
    input  logic                     fifo_full,
    output logic                     push,
    output lrpp_pkg::lrpp_item_t     item
);
    import lrpp_pkg::*;

    logic [15:0]        thr_reg;
    logic signed [18:0] start_reg;
    logic signed [17:0] step_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;
    logic signed [IDX_W+18:0] prod;

    assign cfg_ready = 1'b1;
    assign in_ready  = !fifo_full;
    assign push      = in_valid && in_ready;

    always_comb
    begin
        prod = $signed({1'b0, idx_reg}) * step_reg;
        item.range_mm = range_mm;
        item.hit      = intensity >= thr_reg;
        item.eos      = end_of_scan;
        item.angle    = ANG_W'(prod) + ANG_W'(start_reg);
        idx_next = idx_reg;
        if (push)
        begin
            if (end_of_scan)
                idx_next = '0;
            else if (idx_reg < IDX_W'(MAX_SCAN_SAMPLES - 1))
                idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= THRESHOLD_RESET;
            start_reg <= '0;
            step_reg  <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_THRESHOLD:   thr_reg   <= cfg_data[15:0];
                    CFG_ANGLE_START: start_reg <= $signed(cfg_data);
                    CFG_ANGLE_STEP:  step_reg  <= $signed(cfg_data[17:0]);
                    default: ;
                endcase
            end
        end
    end

endmodule

/* hdl/lrpp_fifo.sv */
// ----------------------------------------------------------------------------
// Reflector pair pose item queue
// A short queue of classified samples between the front and back ends.
// ----------------------------------------------------------------------------
module lrpp_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  lrpp_pkg::lrpp_item_t push_item,
    input  logic                 pop,
    output lrpp_pkg::lrpp_item_t head,
    output logic                 full,
    output logic                 empty
);
    import lrpp_pkg::*;

    lrpp_item_t         mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_reg;
    logic [FIFO_AW-1:0] rd_reg;
    logic [FIFO_AW:0]   cnt_reg;

    assign full  = cnt_reg == (FIFO_AW+1)'(FIFO_DEPTH);
    assign empty = cnt_reg == '0;
    assign head  = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

/* hdl/lrpp_back.sv */
// ----------------------------------------------------------------------------
// Reflector pair pose back end
// Sequencer with a shared CORDIC, a restoring divider and the result register.
// ----------------------------------------------------------------------------
module lrpp_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fifo_empty,
    input  lrpp_pkg::lrpp_item_t head,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 kind,
    output logic [1:0]           status,
    output logic signed [16:0]   pos_x,
    output logic signed [16:0]   pos_y,
    output logic signed [18:0]   heading,
    output logic [7:0]           reflector_count,
    output logic                 last
);
    import lrpp_pkg::*;

    lrpp_state_t state_reg, state_next;
    lrpp_item_t  item_reg, item_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CMP_W-1:0] m_reg, m_next;
    logic neg_reg, neg_next;
    logic flip_reg, flip_next;
    logic signed [CW-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [ZW-1:0] cz_reg, cz_next;
    logic signed [PW-1:0] px_reg, px_next, py_reg, py_next;
    logic signed [SUM_W-1:0] sum_x_reg, sum_x_next, sum_y_reg, sum_y_next;
    logic [RUN_W-1:0] run_len_reg, run_len_next;
    logic in_run_reg, in_run_next;
    logic [7:0] total_reg, total_next;
    logic [DIV_W-1:0] qx_reg, qx_next, qy_reg, qy_next;
    logic [RUN_W-1:0] rx_reg, rx_next, ry_reg, ry_next;
    logic sgx_reg, sgx_next, sgy_reg, sgy_next;
    logic signed [16:0] cen_x_reg [2];
    logic signed [16:0] cen_y_reg [2];
    logic cen_we;
    logic signed [17:0] nvx_reg, nvx_next, nvy_reg, nvy_next;
    logic signed [17:0] sx_reg, sx_next, sy_reg, sy_next;
    logic signed [16:0] mx_reg, mx_next, my_reg, my_next;
    logic signed [18:0] hd_reg, hd_next;
    logic [1:0] st_reg, st_next;

    logic out_valid_reg, out_valid_next;
    logic kind_reg, kind_next, last_reg, last_next;
    logic [1:0] status_reg, status_next;
    logic signed [16:0] pos_x_reg, pos_x_next, pos_y_reg, pos_y_next;
    logic signed [18:0] heading_reg, heading_next;
    logic [7:0] count_reg, count_next;

    logic                    out_free;
    logic [ANG_W-1:0]        amag;
    logic [CMP_W-1:0]        tp;
    logic signed [ZW-1:0]    zr;
    logic signed [CW-1:0]    cc, ss;
    logic signed [16:0]      rng_s;
    logic signed [16:0]      ptx, pty;
    logic [RUN_W:0]          tx, ty;
    logic [DIV_W-1:0]        abx, aby;
    logic signed [16:0]      cenx, ceny;
    logic [7:0]              total_inc;
    logic signed [PW-1:0]    dot;
    logic signed [17:0]      onx, ony;
    logic signed [CW-1:0]    vx, vy;

    function automatic logic signed [16:0] rnd30(input logic signed [PW-1:0] v);
        logic [PW-1:0] mag;
        logic [PW-1:0] t;
        logic [20:0]   r;
        mag = v[PW-1] ? PW'(-v) : PW'(v);
        t   = mag + (PW'(1) << 29);
        r   = t[50:30];
        if (r > 21'd65535)
            r = 21'd65535;
        return v[PW-1] ? -$signed({1'b0, r[15:0]}) : $signed({1'b0, r[15:0]});
    endfunction

    function automatic logic signed [18:0] rnd14(input logic signed [ZW-1:0] v);
        logic [ZW-1:0]      mag;
        logic [ZW-1:0]      t;
        logic signed [22:0] s;
        mag = v[ZW-1] ? ZW'(-v) : ZW'(v);
        t   = mag + (ZW'(1) << 13);
        s   = v[ZW-1] ? -$signed({1'b0, t[35:14]}) : $signed({1'b0, t[35:14]});
        if (s > 23'sd205887)
            s = 23'sd205887;
        else if (s < -23'sd205888)
            s = -23'sd205888;
        return s[18:0];
    endfunction

    assign out_free        = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign kind            = kind_reg;
    assign status          = status_reg;
    assign pos_x           = pos_x_reg;
    assign pos_y           = pos_y_reg;
    assign heading         = heading_reg;
    assign reflector_count = count_reg;
    assign last            = last_reg;

    always_comb
    begin
        state_next = state_reg;   item_next = item_reg;   cnt_next = cnt_reg;
        m_next = m_reg;           neg_next = neg_reg;     flip_next = flip_reg;
        cx_next = cx_reg;         cy_next = cy_reg;       cz_next = cz_reg;
        px_next = px_reg;         py_next = py_reg;
        sum_x_next = sum_x_reg;   sum_y_next = sum_y_reg; run_len_next = run_len_reg;
        in_run_next = in_run_reg; total_next = total_reg;
        qx_next = qx_reg;         qy_next = qy_reg;       rx_next = rx_reg;
        ry_next = ry_reg;         sgx_next = sgx_reg;     sgy_next = sgy_reg;
        nvx_next = nvx_reg;       nvy_next = nvy_reg;     sx_next = sx_reg;
        sy_next = sy_reg;         mx_next = mx_reg;       my_next = my_reg;
        hd_next = hd_reg;         st_next = st_reg;
        kind_next = kind_reg;     last_next = last_reg;   status_next = status_reg;
        pos_x_next = pos_x_reg;   pos_y_next = pos_y_reg;
        heading_next = heading_reg; count_next = count_reg;
        out_valid_next = out_valid_reg && !out_ready;
        pop = 1'b0;
        cen_we = 1'b0;
        amag = head.angle[ANG_W-1] ? ANG_W'(-head.angle) : ANG_W'(head.angle);
        tp = CMP_W'(TWO_PI_U) << cnt_reg;
        zr = $signed(ZW'(m_reg[33:0]));
        cc = flip_reg ? -cx_reg : cx_reg;
        ss = flip_reg ? -cy_reg : cy_reg;
        rng_s = $signed({1'b0, item_reg.range_mm});
        ptx = rnd30(px_reg);
        pty = rnd30(py_reg);
        tx = {rx_reg, qx_reg[DIV_W-1]};
        ty = {ry_reg, qy_reg[DIV_W-1]};
        abx = sum_x_reg[SUM_W-1] ? DIV_W'(-sum_x_reg) : DIV_W'(sum_x_reg);
        aby = sum_y_reg[SUM_W-1] ? DIV_W'(-sum_y_reg) : DIV_W'(sum_y_reg);
        cenx = sgx_reg ? -$signed(qx_reg[16:0]) : $signed(qx_reg[16:0]);
        ceny = sgy_reg ? -$signed(qy_reg[16:0]) : $signed(qy_reg[16:0]);
        total_inc = (total_reg == 8'd255) ? total_reg : total_reg + 8'd1;
        dot = px_reg + py_reg;
        onx = dot[PW-1] ? -nvx_reg : nvx_reg;
        ony = dot[PW-1] ? -nvy_reg : nvy_reg;
        vx = CW'(onx) <<< 12;
        vy = CW'(ony) <<< 12;

        case (state_reg)
            S_IDLE:
            begin
                if (!fifo_empty)
                begin
                    pop = 1'b1;
                    item_next = head;
                    m_next = CMP_W'(amag) << 14;
                    neg_next = head.angle[ANG_W-1];
                    cnt_next = CNT_W'(RED_K);
                    if (!head.hit && in_run_reg)
                        state_next = S_DINIT;
                    else if (head.hit)
                        state_next = S_REDUCE;
                    else if (head.eos)
                        state_next = S_SUMPREP;
                end
            end
            // Angle modulo two pi, one shifted multiple per cycle.
            S_REDUCE:
            begin
                if (m_reg >= tp)
                    m_next = m_reg - tp;
                if (cnt_reg == '0)
                    state_next = S_FOLD;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            S_FOLD:
            begin
                if (neg_reg && zr != '0)
                    zr = TWO_PI_Q30 - zr;
                if (zr > PI_Q30)
                    zr = zr - TWO_PI_Q30;
                cz_next = zr;
                state_next = S_QUAD;
            end
            S_QUAD:
            begin
                flip_next = 1'b0;
                if (cz_reg > HALF_PI_Q30)
                begin
                    cz_next = cz_reg - PI_Q30;
                    flip_next = 1'b1;
                end
                else if (cz_reg < -HALF_PI_Q30)
                begin
                    cz_next = cz_reg + PI_Q30;
                    flip_next = 1'b1;
                end
                cx_next = GAIN_Q30;
                cy_next = '0;
                cnt_next = '0;
                state_next = S_ROT;
            end
            S_ROT:
            begin
                if (cz_reg >= 0)
                begin
                    cx_next = cx_reg - (cy_reg >>> cnt_reg);
                    cy_next = cy_reg + (cx_reg >>> cnt_reg);
                    cz_next = cz_reg - atan_q30(cnt_reg);
                end
                else
                begin
                    cx_next = cx_reg + (cy_reg >>> cnt_reg);
                    cy_next = cy_reg - (cx_reg >>> cnt_reg);
                    cz_next = cz_reg + atan_q30(cnt_reg);
                end
                if (cnt_reg == CNT_W'(CORDIC_ITERATIONS - 1))
                    state_next = S_MUL;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_MUL:
            begin
                px_next = rng_s * cc;
                py_next = rng_s * ss;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (run_len_reg < RUN_W'(MAX_SCAN_SAMPLES))
                begin
                    sum_x_next = sum_x_reg + SUM_W'(ptx);
                    sum_y_next = sum_y_reg + SUM_W'(pty);
                    run_len_next = run_len_reg + 1'b1;
                end
                in_run_next = 1'b1;
                state_next = item_reg.eos ? S_DINIT : S_IDLE;
            end
            S_DINIT:
            begin
                qx_next = abx + DIV_W'(run_len_reg >> 1);
                qy_next = aby + DIV_W'(run_len_reg >> 1);
                sgx_next = sum_x_reg[SUM_W-1];
                sgy_next = sum_y_reg[SUM_W-1];
                rx_next = '0;
                ry_next = '0;
                cnt_next = CNT_W'(DIV_W - 1);
                state_next = S_DIV;
            end
            // Restoring division; the quotient shifts in behind the numerator.
            S_DIV:
            begin
                if (tx >= {1'b0, run_len_reg})
                begin
                    rx_next = RUN_W'(tx - {1'b0, run_len_reg});
                    qx_next = {qx_reg[DIV_W-2:0], 1'b1};
                end
                else
                begin
                    rx_next = tx[RUN_W-1:0];
                    qx_next = {qx_reg[DIV_W-2:0], 1'b0};
                end
                if (ty >= {1'b0, run_len_reg})
                begin
                    ry_next = RUN_W'(ty - {1'b0, run_len_reg});
                    qy_next = {qy_reg[DIV_W-2:0], 1'b1};
                end
                else
                begin
                    ry_next = ty[RUN_W-1:0];
                    qy_next = {qy_reg[DIV_W-2:0], 1'b0};
                end
                if (cnt_reg == '0)
                    state_next = S_CENT;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            S_CENT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next = KIND_CENTROID;
                    status_next = STAT_POSE_VALID;
                    pos_x_next = cenx;
                    pos_y_next = ceny;
                    heading_next = '0;
                    count_next = total_inc;
                    last_next = !item_reg.eos;
                    cen_we = total_reg < 8'd2;
                    total_next = total_inc;
                    in_run_next = 1'b0;
                    sum_x_next = '0;
                    sum_y_next = '0;
                    run_len_next = '0;
                    state_next = item_reg.eos ? S_SUMPREP : S_IDLE;
                end
            end
            S_SUMPREP:
            begin
                if (total_reg == 8'd2)
                begin
                    sx_next = 18'(cen_x_reg[0]) + 18'(cen_x_reg[1]);
                    sy_next = 18'(cen_y_reg[0]) + 18'(cen_y_reg[1]);
                    nvx_next = 18'(cen_y_reg[1]) - 18'(cen_y_reg[0]);
                    nvy_next = 18'(cen_x_reg[0]) - 18'(cen_x_reg[1]);
                    st_next = STAT_POSE_VALID;
                    state_next = S_DOT;
                end
                else
                begin
                    st_next = (total_reg < 8'd2) ? STAT_TOO_FEW : STAT_TOO_MANY;
                    mx_next = '0;
                    my_next = '0;
                    hd_next = '0;
                    state_next = S_EMIT;
                end
            end
            S_DOT:
            begin
                px_next = PW'(nvx_reg * sx_reg);
                py_next = PW'(nvy_reg * sy_reg);
                mx_next = sx_reg[17] ? -17'((-sx_reg + 18'sd1) >>> 1)
                                     : 17'((sx_reg + 18'sd1) >>> 1);
                my_next = sy_reg[17] ? -17'((-sy_reg + 18'sd1) >>> 1)
                                     : 17'((sy_reg + 18'sd1) >>> 1);
                state_next = S_ORIENT;
            end
            S_ORIENT:
            begin
                cnt_next = '0;
                if (onx == '0 && ony == '0)
                begin
                    hd_next = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    if (onx < 0)
                    begin
                        cz_next = (ony >= 0) ? PI_Q30 : -PI_Q30;
                        cx_next = -vx;
                        cy_next = -vy;
                    end
                    else
                    begin
                        cz_next = '0;
                        cx_next = vx;
                        cy_next = vy;
                    end
                    state_next = S_VEC;
                end
            end
            S_VEC:
            begin
                if (cy_reg >= 0)
                begin
                    cx_next = cx_reg + (cy_reg >>> cnt_reg);
                    cy_next = cy_reg - (cx_reg >>> cnt_reg);
                    cz_next = cz_reg + atan_q30(cnt_reg);
                end
                else
                begin
                    cx_next = cx_reg - (cy_reg >>> cnt_reg);
                    cy_next = cy_reg + (cx_reg >>> cnt_reg);
                    cz_next = cz_reg - atan_q30(cnt_reg);
                end
                if (cnt_reg == CNT_W'(CORDIC_ITERATIONS - 1))
                    state_next = S_VFIN;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_VFIN:
            begin
                hd_next = rnd14(cz_reg);
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next = KIND_SUMMARY;
                    status_next = st_reg;
                    pos_x_next = mx_reg;
                    pos_y_next = my_reg;
                    heading_next = hd_reg;
                    count_next = total_reg;
                    last_next = 1'b1;
                    total_next = '0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_run_reg    <= 1'b0;
            total_reg     <= '0;
            run_len_reg   <= '0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_run_reg    <= in_run_next;
            total_reg     <= total_next;
            run_len_reg   <= run_len_next;
            sum_x_reg     <= sum_x_next;
            sum_y_reg     <= sum_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;   cnt_reg <= cnt_next;     m_reg <= m_next;
        neg_reg <= neg_next;     flip_reg <= flip_next;
        cx_reg <= cx_next;       cy_reg <= cy_next;       cz_reg <= cz_next;
        px_reg <= px_next;       py_reg <= py_next;
        qx_reg <= qx_next;       qy_reg <= qy_next;
        rx_reg <= rx_next;       ry_reg <= ry_next;
        sgx_reg <= sgx_next;     sgy_reg <= sgy_next;
        nvx_reg <= nvx_next;     nvy_reg <= nvy_next;
        sx_reg <= sx_next;       sy_reg <= sy_next;
        mx_reg <= mx_next;       my_reg <= my_next;
        hd_reg <= hd_next;       st_reg <= st_next;
        kind_reg <= kind_next;   last_reg <= last_next;   status_reg <= status_next;
        pos_x_reg <= pos_x_next; pos_y_reg <= pos_y_next;
        heading_reg <= heading_next;
        count_reg <= count_next;
        if (cen_we)
        begin
            cen_x_reg[total_reg[0]] <= cenx;
            cen_y_reg[total_reg[0]] <= ceny;
        end
    end

endmodule

/* hdl/laser_reflector_pair_pose.sv */
// ----------------------------------------------------------------------------
// Laser reflector pair pose
// Finds reflector runs in a laser scan and the pose of a reflector pair.
// ----------------------------------------------------------------------------
// Samples enter through a four-entry queue and are worked one at a time by a
// single sequencer with a shared CORDIC and a restoring divider. A sample below
// the threshold that closes no run is just taken from the queue. A reflector
// sample is taken from the queue, its angle is reduced modulo two pi and folded,
// the CORDIC rotates it, and its point is scaled and added to the run sums.
// Closing a run adds a setup step, the division steps and the centroid transfer
// into the output register. An end of scan summary with a valid pair is mostly
// made up of the CORDIC vectoring steps. Results wait in a single output
// register; the sequencer keeps working while a result is held and stalls only
// when its next result is ready before that one has left.
// ----------------------------------------------------------------------------
module laser_reflector_pair_pose (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [18:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [15:0]        range_mm,
    input  logic [15:0]        intensity,
    input  logic               end_of_scan,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               kind,
    output logic [1:0]         status,
    output logic signed [16:0] pos_x,
    output logic signed [16:0] pos_y,
    output logic signed [18:0] heading,
    output logic [7:0]         reflector_count,
    output logic               last
);
    import lrpp_pkg::*;

    lrpp_item_t push_item;
    lrpp_item_t head;
    logic       push;
    logic       pop;
    logic       full;
    logic       empty;

    lrpp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .range_mm    (range_mm),
        .intensity   (intensity),
        .end_of_scan (end_of_scan),
        .fifo_full   (full),
        .push        (push),
        .item        (push_item)
    );

    lrpp_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .full      (full),
        .empty     (empty)
    );

    lrpp_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .fifo_empty      (empty),
        .head            (head),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .kind            (kind),
        .status          (status),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .heading         (heading),
        .reflector_count (reflector_count),
        .last            (last)
    );

    // A summary always ends the results of its sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_SUMMARY) |-> last)
        else $error("summary transfer without last");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_CENTROID)
            |-> (heading == '0 && status == STAT_POSE_VALID))
        else $error("centroid with heading or status set");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != STAT_POSE_VALID)
            |-> (heading == '0 && pos_x == '0 && pos_y == '0))
        else $error("invalid pose with nonzero fields");

endmodule
